@@ hw/rtl/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared types, surrogate constants and the code point encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // Surrogate ranges, upper six bits of the code unit
  localparam logic [5:0] SurHighTag = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] SurLowTag  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] SuppBase  = 21'h010000;

  localparam int unsigned EntryBytes = 6;

  // One encoded code point, up to four bytes, lowest index sent first
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_seq_t;

  // Work handed from front to back: all bytes one unit causes
  typedef struct packed {
    logic [EntryBytes-1:0][7:0] bytes;
    logic [2:0]                 nbytes;
  } u16u8_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } u16u8_fifo_status_t;

  // Encode one code point (at most 0x10FFFF) as 1 to 4 UTF-8 bytes
  function automatic utf8_seq_t encode_point(input logic [20:0] cp);
    utf8_seq_t s;
    s = '0;
    if (cp < 21'h80) begin
      s.b[0] = {1'b0, cp[6:0]};
      s.n    = 3'd1;
    end else if (cp < 21'h800) begin
      s.b[0] = {3'b110, cp[10:6]};
      s.b[1] = {2'b10, cp[5:0]};
      s.n    = 3'd2;
    end else if (cp < SuppBase) begin
      s.b[0] = {4'b1110, cp[15:12]};
      s.b[1] = {2'b10, cp[11:6]};
      s.b[2] = {2'b10, cp[5:0]};
      s.n    = 3'd3;
    end else begin
      s.b[0] = {5'b11110, cp[20:18]};
      s.b[1] = {2'b10, cp[17:12]};
      s.b[2] = {2'b10, cp[11:6]};
      s.b[3] = {2'b10, cp[5:0]};
      s.n    = 3'd4;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front end
// Accepts code units, pairs surrogates and builds the byte entry per unit.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [15:0]                  code_unit_i,
  input  logic                         final_unit_i,
  input  u16u8_pkg::u16u8_fifo_status_t fifo_st_i,
  output logic                         push_o,
  output u16u8_pkg::u16u8_entry_t      entry_o
);
  import u16u8_pkg::*;

  logic [9:0] held_high_q, held_high_d;
  logic       held_valid_q, held_valid_d;
  logic       accept;
  logic       is_high, is_low, main_en;
  logic [20:0] pair_cp;
  utf8_seq_t  seq_pair, seq_held, seq_main;
  logic [2:0] main_n;

  assign ready_o = !fifo_st_i.full;
  assign accept  = valid_i && ready_o;

  // Classify the unit
  assign is_high = (code_unit_i[15:10] == SurHighTag);
  assign is_low  = (code_unit_i[15:10] == SurLowTag);
  assign main_en = !(is_high && !final_unit_i);

  // Encoders for the joined pair, the held unit alone and the new unit
  assign pair_cp  = SuppBase + {1'b0, held_high_q, code_unit_i[9:0]};
  assign seq_pair = encode_point(pair_cp);
  assign seq_held = encode_point({5'd0, SurHighTag, held_high_q});
  assign seq_main = encode_point({5'd0, code_unit_i});
  assign main_n   = main_en ? seq_main.n : 3'd0;

  // Build the entry
  always_comb begin
    entry_o = '0;
    if (held_valid_q && is_low) begin
      entry_o.bytes[3:0] = seq_pair.b;
      entry_o.nbytes     = seq_pair.n;
    end else if (held_valid_q) begin
      entry_o.bytes[2:0] = seq_held.b[2:0];
      entry_o.bytes[5:3] = seq_main.b[2:0];
      entry_o.nbytes     = 3'd3 + main_n;
    end else begin
      entry_o.bytes[3:0] = seq_main.b;
      entry_o.nbytes     = main_n;
    end
  end

  assign push_o = accept && (entry_o.nbytes != 3'd0);

  // Hold a high surrogate that does not end the string
  always_comb begin
    held_valid_d = held_valid_q;
    held_high_d  = held_high_q;
    if (accept) begin
      held_valid_d = is_high && !final_unit_i && !(held_valid_q && is_low);
      held_high_d  = held_valid_d ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_high_q  <= 10'd0;
    end else begin
      held_valid_q <= held_valid_d;
      held_high_q  <= held_high_d;
    end
  end

endmodule

@@ hw/rtl/u16u8_fifo.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 entry queue
// Short queue of byte entries between front and back.
// ----------------------------------------------------------------------------
module u16u8_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  u16u8_pkg::u16u8_entry_t       entry_i,
  input  logic                          pop_i,
  output u16u8_pkg::u16u8_entry_t       entry_o,
  output u16u8_pkg::u16u8_fifo_status_t status_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u16u8_entry_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

@@ hw/rtl/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 back end
// Takes entries from the queue and sends their bytes one beat at a time.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  u16u8_pkg::u16u8_entry_t       entry_i,
  input  u16u8_pkg::u16u8_fifo_status_t fifo_st_i,
  output logic                          pop_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [7:0]                    utf8_byte_o,
  output logic                          run_end_o
);
  import u16u8_pkg::*;

  logic [EntryBytes-2:0][7:0] rest_q, rest_d;
  logic [2:0]                 rem_q, rem_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;
  logic                       advance;

  assign advance = !out_valid_q || ready_i;
  assign pop_o   = advance && (rem_q == 3'd0) && !fifo_st_i.empty;

  // Next beat: drain the current entry, else load a fresh one
  always_comb begin
    rest_d      = rest_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (advance) begin
      if (rem_q != 3'd0) begin
        out_valid_d = 1'b1;
        out_byte_d  = rest_q[0];
        out_last_d  = (rem_q == 3'd1);
        rest_d      = {8'd0, rest_q[EntryBytes-2:1]};
        rem_d       = rem_q - 3'd1;
      end else if (pop_o) begin
        out_valid_d = 1'b1;
        out_byte_d  = entry_i.bytes[0];
        out_last_d  = (entry_i.nbytes == 3'd1);
        rest_d      = entry_i.bytes[EntryBytes-1:1];
        rem_d       = entry_i.nbytes - 3'd1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q     <= rest_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign valid_o     = out_valid_q;
  assign utf8_byte_o = out_byte_q;
  assign run_end_o   = out_last_q;

endmodule

@@ hw/rtl/utf16_to_utf8_transcoder_core.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder core
// Path: a unit's entry is written into the entry queue, and its first byte is
//   then loaded into the output register when the output stage is free.
// Output: one byte per cycle from the output serialiser while the sink is
//   ready; a unit causes 0 to 6 bytes, and one with no bytes pushes no entry.
// The front takes a unit each cycle while the entry queue has room.
// Reset: asynchronous, clears the pending surrogate, queue and output stage.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // final_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] utf8_byte
  output logic        m_axis_tlast    // run_end
);
  import u16u8_pkg::*;

  u16u8_fifo_status_t fifo_st;
  u16u8_entry_t       push_entry, head_entry;
  logic               push, pop;

  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .code_unit_i  (s_axis_tdata),
    .final_unit_i (s_axis_tlast),
    .fifo_st_i    (fifo_st),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  u16u8_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (fifo_st)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .fifo_st_i   (fifo_st),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .utf8_byte_o (m_axis_tdata),
    .run_end_o   (m_axis_tlast)
  );

  // Front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_st.full)
    else $error("push into full entry queue");

  // Every pushed entry carries one to six bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_entry.nbytes != 3'd0) && (push_entry.nbytes <= 3'd6))
    else $error("bad byte count in entry");

  // Back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("pop from empty entry queue");

  // A popped entry shows up on the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid)
    else $error("popped entry not presented");

endmodule
